>>> rtl/rva_pkg.sv
package rva_pkg;

	localparam int ROW_W    = 10;
	localparam int VAL_W    = 16;
	localparam int N_W      = 16;
	localparam int SUM_W    = 33;
	localparam int SQ_W     = 47;
	localparam int VAR_W    = 38;
	localparam int DIFF_W   = 63;
	localparam int S2_W     = 64;
	localparam int DEN_W    = 32;
	localparam int NUM_W    = DIFF_W + 8;
	localparam int CNT_W    = $clog2(NUM_W + 1);
	localparam int ROW_EXT_W = 17;

	localparam int DEFAULT_ROW_COUNT = 1024;

	localparam logic [N_W-1:0]   COLUMN_COUNT_RESET = N_W'(1);
	localparam logic [VAR_W-1:0] VAR_MAX            = '1;

	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef struct packed {
		logic                    cmd;
		logic [ROW_W-1:0]        row_index;
		logic signed [VAL_W-1:0] sample_value;
	} rva_in_t;

	typedef struct packed {
		logic [ROW_W-1:0] result_row;
		logic [VAR_W-1:0] variance_value;
		logic             clamped_flag;
	} rva_out_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [SQ_W-1:0]         sq;
	} rva_acc_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic clr_we;
		logic add_we;
		logic mul_en;
		logic sub_en;
		logic load_out;
	} rva_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_read;
		logic in_range;
		logic clr_last;
		logic neg_now;
		logic div_busy;
		logic out_busy;
	} rva_sts_t;

endpackage

>>> rtl/rva_divider.sv
module rva_divider (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [rva_pkg::DIFF_W-1:0]   diff,
	input  logic [rva_pkg::DEN_W-1:0]    den,
	output logic                         busy,
	output logic [rva_pkg::VAR_W-1:0]    quotient
);
	import rva_pkg::*;

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [VAR_W-1:0] quo_q;
	logic             sat_q;

	logic [DEN_W:0] trial;
	logic           ge;
	logic [DEN_W:0] trial_sub;

	// one restoring step per cycle over diff * 256
	assign trial     = {rem_q, num_q[NUM_W-1]};
	assign ge        = trial >= {1'b0, den_q};
	assign trial_sub = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {diff, 8'd0};
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
			sat_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[VAR_W-2:0], ge};
			// any bit pushed out of the top means the result saturates
			sat_q <= sat_q | quo_q[VAR_W-1];
		end
	end

	assign busy     = busy_q;
	assign quotient = sat_q ? VAR_MAX : quo_q;

endmodule

>>> rtl/rva_datapath.sv
module rva_datapath #(
	parameter int ROW_COUNT = rva_pkg::DEFAULT_ROW_COUNT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [rva_pkg::N_W-1:0]   cfg_data,
	input  rva_pkg::rva_in_t          sample_data,
	input  logic                      result_ready,
	output logic                      result_valid,
	output rva_pkg::rva_out_t         result_data,
	input  rva_pkg::rva_cmd_t         cmd,
	output rva_pkg::rva_sts_t         sts
);
	import rva_pkg::*;

	localparam int ADDR_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

	rva_acc_t mem [ROW_COUNT];

	logic [N_W-1:0]    column_count_q;
	logic [N_W-1:0]    n_eff;

	logic [ROW_W-1:0]       row_q;
	logic [ADDR_W-1:0]      addr_q;
	logic                   in_range_q;
	logic signed [VAL_W-1:0] val_q;
	logic [2*VAL_W-1:0]     sq_in_q;
	rva_acc_t               rd_q;
	logic [ADDR_W-1:0]      clr_addr_q;

	logic [ROW_EXT_W-1:0] row_ext;
	logic                 in_range_c;
	logic [VAL_W-1:0]     mag_c;

	logic [DIFF_W-1:0] nsq_q;
	logic [S2_W-1:0]   s2_q;
	logic [DEN_W-1:0]  den_q;
	logic              big_q;
	logic [SUM_W-1:0]  m_c;
	logic              neg_q;
	logic              neg_c;
	logic [DIFF_W-1:0] diff_c;
	logic              div_start;
	logic              div_busy;
	logic [VAR_W-1:0]  quotient;

	logic              out_valid_q;
	rva_out_t          out_q;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	rva_acc_t          mem_wdata;
	rva_acc_t          acc_new;

	// column count register, zero behaves as one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= COLUMN_COUNT_RESET;
		end else if (cfg_we) begin
			column_count_q <= cfg_data;
		end
	end
	assign n_eff = (column_count_q == '0) ? N_W'(1) : column_count_q;

	assign row_ext    = ROW_EXT_W'(sample_data.row_index);
	assign in_range_c = row_ext < ROW_EXT_W'(ROW_COUNT);
	assign mag_c      = sample_data.sample_value[VAL_W-1]
	                    ? (~sample_data.sample_value + VAL_W'(1))
	                    : sample_data.sample_value;

	// item capture and registered memory read
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			row_q      <= sample_data.row_index;
			addr_q     <= row_ext[ADDR_W-1:0];
			in_range_q <= in_range_c;
			val_q      <= sample_data.sample_value;
			sq_in_q    <= mag_c * mag_c;
			rd_q       <= mem[row_ext[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_we) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
		end
	end

	assign acc_new.sum = rd_q.sum + SUM_W'(val_q);
	assign acc_new.sq  = rd_q.sq + SQ_W'(sq_in_q);

	// one write port: clearing sweep, add write-back or read-clear
	assign mem_we    = cmd.clr_we | cmd.add_we | (cmd.mul_en & in_range_q);
	assign mem_waddr = cmd.clr_we ? clr_addr_q : addr_q;
	assign mem_wdata = cmd.add_we ? acc_new : '0;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	// products of the variance numerator and denominator
	assign m_c = rd_q.sum[SUM_W-1] ? (~$unsigned(rd_q.sum) + SUM_W'(1)) : $unsigned(rd_q.sum);

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			nsq_q <= DIFF_W'(n_eff) * DIFF_W'(rd_q.sq);
			s2_q  <= S2_W'(m_c[DEN_W-1:0]) * S2_W'(m_c[DEN_W-1:0]);
			den_q <= DEN_W'(n_eff) * DEN_W'(n_eff);
			big_q <= m_c[SUM_W-1];
		end
	end

	assign neg_c     = big_q | (S2_W'(nsq_q) < s2_q);
	assign diff_c    = nsq_q - s2_q[DIFF_W-1:0];
	assign div_start = cmd.sub_en & ~neg_c;

	always_ff @(posedge clk) begin
		if (cmd.sub_en) begin
			neg_q <= neg_c;
		end
	end

	rva_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.diff     (diff_c),
		.den      (den_q),
		.busy     (div_busy),
		.quotient (quotient)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.result_row     <= row_q;
			out_q.variance_value <= (in_range_q && !neg_q) ? quotient : '0;
			out_q.clamped_flag   <= in_range_q & neg_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result_data  = out_q;

	assign sts.is_read  = sample_data.cmd == CMD_READ;
	assign sts.in_range = in_range_q;
	assign sts.clr_last = clr_addr_q == ADDR_W'(ROW_COUNT - 1);
	assign sts.neg_now  = neg_c;
	assign sts.div_busy = div_busy;
	assign sts.out_busy = out_valid_q & ~result_ready;

	a_load_free : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_valid_q && !result_ready))
		else $error("result loaded over a waiting item");
	a_load_valid : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("loaded result not presented");
	a_one_write : assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_we, cmd.add_we, cmd.mul_en}))
		else $error("two memory writers at once");
	a_div_idle : assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

endmodule

>>> rtl/rva_controller.sv
module rva_controller (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  rva_pkg::rva_sts_t  sts,
	output rva_pkg::rva_cmd_t  cmd
);
	import rva_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_ADD   = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_SUB   = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.accept = sample_valid;
				if (sample_valid) begin
					state_d = sts.is_read ? ST_MUL : ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.add_we = sts.in_range;
				state_d    = ST_IDLE;
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = sts.in_range ? ST_SUB : ST_OUT;
			end
			ST_SUB: begin
				cmd.sub_en = 1'b1;
				state_d    = sts.neg_now ? ST_OUT : ST_DIV;
			end
			ST_DIV: begin
				if (!sts.div_busy) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign sample_ready = state_q == ST_IDLE;

	a_clear_first : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && !sts.clr_last) |=> state_q == ST_CLEAR)
		else $error("clearing sweep left early");
	a_add_return : assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && !sts.is_read) |=> ##1 sample_ready)
		else $error("add did not finish in two cycles");
	a_div_wait : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUB && !sts.neg_now) |=> sts.div_busy)
		else $error("divider not running after start");

endmodule

>>> rtl/row_variance_accumulator.sv
// row variance accumulator
// keeps a running sum and sum of squares per row; items arrive on the sample
// channel (valid/ready), results leave on the result channel (valid/ready)
// cmd add: sample_value is added to row_index; gives no item
// cmd read: returns (n*S2 - S*S) / n^2 in 8 fraction bits, floored, then
//   clears the row; the result comes from the bit-serial divider, which
//   produces one quotient bit per cycle over 71 bits, and the next item can be
//   taken in the same cycle that result_valid rises
// a read that finds the numerator negative skips the divider and returns 0
// with clamped_flag set; an out-of-range row returns 0 and touches nothing
// column_count is written through cfg_we/cfg_data, by the user only while
// idle, which the block itself does not enforce; zero acts as one
// after reset the accumulator memory is swept to zero, one row per cycle
//   across all ROW_COUNT rows, with sample_ready low; column_count resets to 1
// the result sits in an output register: an add is still accepted while a
// result waits, a read waits before its final step until the receiver takes
// the previous result
module row_variance_accumulator #(
	parameter int ROW_COUNT = rva_pkg::DEFAULT_ROW_COUNT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [rva_pkg::N_W-1:0]  cfg_data,
	input  logic                     sample_valid,
	output logic                     sample_ready,
	input  rva_pkg::rva_in_t         sample_data,
	output logic                     result_valid,
	input  logic                     result_ready,
	output rva_pkg::rva_out_t        result_data
);
	import rva_pkg::*;

	// command and status between sequencer and datapath
	rva_cmd_t cmd;
	rva_sts_t sts;

	rva_controller u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	// memory, multipliers, divider and output register
	rva_datapath #(
		.ROW_COUNT (ROW_COUNT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.sample_data  (sample_data),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result_data  (result_data),
		.cmd          (cmd),
		.sts          (sts)
	);

endmodule

>>> tb/row_variance_accumulator_tb.sv
`timescale 1ns / 1ps

module row_variance_accumulator_tb;
	import rva_pkg::*;

	localparam int ROWS = DEFAULT_ROW_COUNT;
	// longest run of cycles with no item moving on either channel; covers the
	// reset sweep of all rows and a read waiting out a stalled receiver
	localparam int STALL_LIMIT = 5000;
	// an add is still in flight after its item is taken
	localparam int ADD_SETTLE = 12;
	localparam int DRAIN_CYCLES = 120;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

	// per-row sum / sum of squares, and the variances still owed to the receiver
	class variance_scoreboard;
		logic signed [SUM_W-1:0] row_sum [ROWS];
		logic [SQ_W-1:0]         row_sq [ROWS];
		logic [N_W-1:0]          columns;
		rva_out_t                awaited[$];
		int                      errors;

		function new();
			foreach (row_sum[i]) begin
				row_sum[i] = '0;
				row_sq[i] = '0;
			end
			columns = COLUMN_COUNT_RESET;
			errors = 0;
		endfunction

		function void set_columns(logic [N_W-1:0] value);
			columns = value;
		endfunction

		// (n*S2 - S*S) / n^2 in 8 fraction bits, worked in wide unsigned arithmetic
		function rva_out_t row_variance(logic [ROW_W-1:0] row);
			rva_out_t r;
			logic [SUM_W-1:0] s_bits;
			logic [SUM_W-1:0] mag;
			logic [127:0] n, s2, nsq, q;
			n = (columns == '0) ? 128'd1 : 128'(columns);
			s_bits = row_sum[row];
			// magnitude of the signed sum; the most negative sum gives 2^32
			mag = s_bits[SUM_W-1] ? (~s_bits + 1'b1) : s_bits;
			s2 = 128'(mag) * 128'(mag);
			nsq = n * 128'(row_sq[row]);
			r.result_row = row;
			r.variance_value = '0;
			r.clamped_flag = 1'b0;
			if (nsq < s2) begin
				// more entries than columns can drive the numerator negative
				r.clamped_flag = 1'b1;
			end else begin
				q = ((nsq - s2) << 8) / (n * n);
				// too large for the result field: saturate, flag stays low
				r.variance_value = (q > 128'(VAR_MAX)) ? VAR_MAX : q[VAR_W-1:0];
			end
			return r;
		endfunction

		function void note_item(rva_in_t it);
			logic signed [SUM_W-1:0] ext;
			logic [VAL_W:0] vmag;
			if (it.cmd == CMD_ADD) begin
				ext = it.sample_value;
				vmag = it.sample_value[VAL_W-1] ? (17'h10000 - {1'b0, it.sample_value})
					: {1'b0, it.sample_value};
				// both accumulators wrap at their widths
				row_sum[it.row_index] = row_sum[it.row_index] + ext;
				row_sq[it.row_index] = row_sq[it.row_index] + SQ_W'(vmag) * SQ_W'(vmag);
			end else begin
				// read returns the variance and clears the row; sample_value unused
				awaited.push_back(row_variance(it.row_index));
				row_sum[it.row_index] = '0;
				row_sq[it.row_index] = '0;
			end
		endfunction

		task report(string what, logic [63:0] want, logic [63:0] got);
			$display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
			errors++;
		endtask

		task check_result(rva_out_t got);
			rva_out_t want;
			if (awaited.size() == 0) begin
				report("result with no read waiting, row", 0, got.result_row);
				return;
			end
			want = awaited.pop_front();
			if (got.result_row !== want.result_row)
				report("result_row", want.result_row, got.result_row);
			if (got.variance_value !== want.variance_value)
				report("variance_value", want.variance_value, got.variance_value);
			if (got.clamped_flag !== want.clamped_flag)
				report("clamped_flag", want.clamped_flag, got.clamped_flag);
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [N_W-1:0]   cfg_data;
	logic             sample_valid;
	logic             sample_ready;
	rva_in_t          sample_data;
	logic             result_valid;
	logic             result_ready;
	rva_out_t         result_data;

	variance_scoreboard sb;
	idle_mode_e idle_mode;
	int sender_gap_pct;
	int receiver_stall_pct;
	int items_sent;
	int quiet_cycles;

	row_variance_accumulator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample_data  (sample_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// gap and stall rates per idling phase
	always @(idle_mode) begin
		case (idle_mode)
			IDLE_NONE: begin
				sender_gap_pct = 0;
				receiver_stall_pct = 0;
			end
			IDLE_SENDER: begin
				sender_gap_pct = 53;
				receiver_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				sender_gap_pct = 0;
				receiver_stall_pct = 53;
			end
			default: begin
				sender_gap_pct = 16;
				receiver_stall_pct = 16;
			end
		endcase
	end

	// receiver: ready changes on the falling edge only
	always @(negedge clk) begin
		if (arst_n)
			result_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	// both channels are sampled at the rising edge, before any register moves
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && sample_ready)
				sb.note_item(sample_data);
			if (result_valid && result_ready)
				sb.check_result(result_data);
		end
	end

	// watchdog: ends a run in which nothing moves for too long
	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (result_valid && result_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("row_variance_accumulator_tb: FAIL");
			$finish;
		end
	end

	function automatic rva_in_t make_item(logic cmd, logic [ROW_W-1:0] row,
		logic signed [VAL_W-1:0] value);
		rva_in_t it;
		it.cmd = cmd;
		it.row_index = row;
		it.sample_value = value;
		return it;
	endfunction

	// extremes of the value range show up often, the rest is uniform
	function automatic logic signed [VAL_W-1:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return '0;
			3: return '1;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic logic [ROW_W-1:0] pick_row();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return ROW_W'($urandom_range(0, ROWS - 1));
		endcase
	endfunction

	// called and returns at a falling edge; holds valid until the item is taken
	task automatic push_item(rva_in_t it);
		while ($urandom_range(0, 99) < sender_gap_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		sample_data <= it;
		do
			@(posedge clk);
		while (!sample_ready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic push_add(logic [ROW_W-1:0] row, logic signed [VAL_W-1:0] value);
		push_item(make_item(CMD_ADD, row, value));
	endtask

	task automatic push_read(logic [ROW_W-1:0] row);
		// the value is ignored by a read, so it carries noise
		push_item(make_item(CMD_READ, row, VAL_W'($urandom)));
	endtask

	// drain every owed result and let trailing adds land before a register write
	task automatic settle();
		sample_valid <= 1'b0;
		while (sb.awaited.size() != 0)
			@(negedge clk);
		repeat (ADD_SETTLE) @(negedge clk);
	endtask

	task automatic write_columns(logic [N_W-1:0] value);
		settle();
		cfg_we <= 1'b1;
		cfg_data <= value;
		sb.set_columns(value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly whole rows (up to n entries, at most 10, sometimes overfilled, then a read) with interleaved noise
	task automatic random_phase(logic [N_W-1:0] columns, idle_mode_e mode, int count);
		int n_eff;
		int entries;
		int stop_at;
		logic [ROW_W-1:0] row;
		write_columns(columns);
		idle_mode = mode;
		n_eff = (columns == '0) ? 1 : int'(columns);
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 99) < 70) begin
				row = pick_row();
				entries = $urandom_range(0, (n_eff < 10) ? n_eff : 10);
				// overfilled row: tends toward a negative numerator
				if (n_eff <= 8 && $urandom_range(0, 9) == 0)
					entries = n_eff + $urandom_range(1, 3);
				for (int i = 0; i < entries; i++) begin
					if ($urandom_range(0, 3) == 0)
						push_add(ROW_W'($urandom_range(0, 7)), rand_value());
					push_add(row, rand_value());
				end
				push_read(row);
			end else begin
				// loose item on a few hot rows or anywhere
				row = ($urandom_range(0, 1) == 0) ? ROW_W'($urandom_range(0, 7)) : pick_row();
				push_item(make_item(1'($urandom), row, rand_value()));
			end
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		sample_valid = 1'b0;
		sample_data = '0;
		result_ready = 1'b0;
		items_sent = 0;
		quiet_cycles = 0;
		idle_mode = IDLE_NONE;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// the row sweep after reset holds sample_ready low
		while (!sample_ready)
			@(negedge clk);

		// directed, column count at its reset value of one
		push_read(10'd0);
		push_add(10'd0, 16'sh7fff);
		push_add(10'd0, 16'sh8000);
		push_read(10'd0);                 // huge spread with n = 1: saturates
		push_add(10'd1023, 16'sd5);
		push_add(10'd1023, 16'sd5);
		push_read(10'd1023);              // two entries in one column: clamped
		push_add(10'd512, 16'sh8000);
		push_read(10'd512);               // single full-scale entry: exactly zero
		push_item(make_item(CMD_READ, 10'd512, 16'sh7fff));  // cleared row

		// widest column count: sparse rows, mostly absent zeros
		write_columns(16'hffff);
		push_add(10'd1, 16'sh7fff);
		push_add(10'd1, 16'sh8000);
		push_read(10'd1);
		push_add(10'd2, -16'sd1);
		push_read(10'd2);

		// zero acts as one
		write_columns(16'd0);
		push_add(10'd3, 16'sd7);
		push_add(10'd3, 16'sd7);
		push_read(10'd3);
		push_add(10'd4, 16'sh8000);
		push_read(10'd4);

		// two columns at opposite extremes: close to the largest variance
		write_columns(16'd2);
		push_add(10'd5, 16'sh7fff);
		push_add(10'd5, 16'sh8000);
		push_read(10'd5);

		random_phase(16'd1, IDLE_NONE, 90);
		random_phase(16'd2, IDLE_SENDER, 90);
		random_phase(16'hffff, IDLE_RECEIVER, 90);
		random_phase(16'd0, IDLE_BOTH, 90);
		random_phase(N_W'($urandom_range(3, 12)), IDLE_NONE, 90);
		random_phase(16'd5, IDLE_SENDER, 90);
		random_phase(N_W'($urandom_range(13, 400)), IDLE_RECEIVER, 90);
		random_phase(N_W'($urandom_range(1, 65535)), IDLE_BOTH, 90);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("row_variance_accumulator_tb: PASS");
		else
			$display("row_variance_accumulator_tb: FAIL");
		$finish;
	end

endmodule

>>> files.f
rtl/rva_pkg.sv
rtl/rva_divider.sv
rtl/rva_datapath.sv
rtl/rva_controller.sv
rtl/row_variance_accumulator.sv
tb/row_variance_accumulator_tb.sv
